/* src/ibh_pkg.sv */
// Shared types and constants for the identifier bitmap block.
package ibh_pkg;

    localparam int ID_BITS   = 16;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WADDR_W   = ID_BITS - BIT_W;
    localparam int NUM_WORDS = 1 << WADDR_W;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TEST   = 2'd1,
        OP_HOLE   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic                 en;
        logic [WADDR_W-1:0]   addr;
        logic [WORD_BITS-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } scan_res_t;

endpackage

/* src/ibh_if.sv */
// Request and response channel interfaces for the identifier bitmap block.
interface ibh_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [ibh_pkg::ID_BITS-1:0] ident;

    modport source (output valid, output operation, output ident, input ready);
    modport sink   (input valid, input operation, input ident, output ready);
endinterface

interface ibh_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [ibh_pkg::ID_BITS-1:0] hole_id;
    logic                        any_present;
    logic [ibh_pkg::ID_BITS-1:0] lowest_id;
    logic [ibh_pkg::ID_BITS-1:0] highest_id;

    modport source (output valid, output hit, output hole_id, output any_present,
                    output lowest_id, output highest_id, input ready);
    modport sink   (input valid, input hit, input hole_id, input any_present,
                    input lowest_id, input highest_id, output ready);
endinterface

/* src/ibh_mem.sv */
// Occupancy word store: one write port, one registered read port.
module ibh_mem (
    input  logic                               clk,
    input  ibh_pkg::mem_wr_t                   wr,
    input  logic [ibh_pkg::WADDR_W-1:0]        raddr,
    output logic [ibh_pkg::WORD_BITS-1:0]      rdata
);

    logic [ibh_pkg::WORD_BITS-1:0] mem [ibh_pkg::NUM_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* src/ibh_scan.sv */
// Word scanner: lowest clear bit at or above a start position.
module ibh_scan (
    input  logic [ibh_pkg::WORD_BITS-1:0] word,
    input  logic [ibh_pkg::BIT_W-1:0]     start,
    output ibh_pkg::scan_res_t            res
);

    logic [ibh_pkg::WORD_BITS-1:0] below;
    logic [ibh_pkg::WORD_BITS-1:0] masked;

    always_comb
    begin
        below  = (ibh_pkg::WORD_BITS'(1) << start) - ibh_pkg::WORD_BITS'(1);
        masked = word | below;
        res    = '0;
        for (int i = ibh_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (!masked[i])
            begin
                res.found = 1'b1;
                res.pos   = ibh_pkg::BIT_W'(i);
            end
        end
    end

endmodule

/* src/id_bitmap_with_hole_search_core.sv */
// Identifier occupancy bitmap with insert, test and next-hole search.
// Insert and test read the addressed word first; an unused op goes straight to the result.
// Hole search scans one stored word per cycle, up to the word of the highest
// identifier; with an empty map or a start past that word it goes straight to the result.
// One word in flight; the next request is taken in the cycle after the result is taken.
// After reset all 2048 store words are swept to zero before the first request is taken.
module id_bitmap_with_hole_search_core (
    input  logic         clk,
    input  logic         rst_n,
    ibh_req_if.sink      req,
    ibh_rsp_if.source    rsp
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS,
        ST_TST,
        ST_SRCH,
        ST_OUT
    } state_t;

    state_t                          state_reg, state_next;
    logic [ibh_pkg::WADDR_W-1:0]     clr_reg, clr_next;
    logic [ibh_pkg::WADDR_W-1:0]     w_reg, w_next;
    logic [ibh_pkg::BIT_W-1:0]       s_reg, s_next;
    logic                            hit_reg, hit_next;
    logic [ibh_pkg::ID_BITS-1:0]     hole_reg, hole_next;
    logic                            nonempty_reg, nonempty_next;
    logic [ibh_pkg::ID_BITS-1:0]     lowest_reg, lowest_next;
    logic [ibh_pkg::ID_BITS-1:0]     highest_reg, highest_next;

    ibh_pkg::mem_wr_t                mem_wr;
    logic [ibh_pkg::WADDR_W-1:0]     raddr;
    logic [ibh_pkg::WORD_BITS-1:0]   rdata;
    ibh_pkg::scan_res_t              scan;

    logic [ibh_pkg::WADDR_W-1:0]     req_word;
    logic [ibh_pkg::WADDR_W-1:0]     top_word;
    logic [ibh_pkg::ID_BITS-1:0]     cur_id;
    logic                            req_fire;

    ibh_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    ibh_scan u_scan (
        .word  (rdata),
        .start (s_reg),
        .res   (scan)
    );

    assign req_word = req.ident[ibh_pkg::ID_BITS-1:ibh_pkg::BIT_W];
    assign top_word = highest_reg[ibh_pkg::ID_BITS-1:ibh_pkg::BIT_W];
    assign cur_id   = {w_reg, s_reg};
    assign req_fire = req.valid && req.ready;

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = (state_reg == ST_OUT);
    assign rsp.hit         = hit_reg;
    assign rsp.hole_id     = hole_reg;
    assign rsp.any_present = nonempty_reg;
    assign rsp.lowest_id   = lowest_reg;
    assign rsp.highest_id  = highest_reg;

    always_comb
    begin
        case (state_reg)
            ST_IDLE: raddr = req_word;
            ST_SRCH: raddr = w_reg + ibh_pkg::WADDR_W'(1);
            default: raddr = w_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        w_next        = w_reg;
        s_next        = s_reg;
        hit_next      = hit_reg;
        hole_next     = hole_reg;
        nonempty_next = nonempty_reg;
        lowest_next   = lowest_reg;
        highest_next  = highest_reg;
        mem_wr        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = clr_reg;
                mem_wr.data = '0;
                clr_next    = clr_reg + ibh_pkg::WADDR_W'(1);
                if (clr_reg == ibh_pkg::WADDR_W'(ibh_pkg::NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    w_next    = req_word;
                    s_next    = req.ident[ibh_pkg::BIT_W-1:0];
                    hit_next  = 1'b0;
                    hole_next = '0;
                    case (ibh_pkg::op_t'(req.operation))
                        ibh_pkg::OP_INSERT: state_next = ST_INS;
                        ibh_pkg::OP_TEST:   state_next = ST_TST;
                        ibh_pkg::OP_HOLE:
                        begin
                            if (nonempty_reg && (req_word <= top_word))
                                state_next = ST_SRCH;
                            else
                                state_next = ST_OUT;
                        end
                        default:            state_next = ST_OUT;
                    endcase
                end
            end
            ST_INS:
            begin
                if (rdata[s_reg])
                begin
                    hit_next = 1'b1;
                end
                else
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = w_reg;
                    mem_wr.data = rdata | (ibh_pkg::WORD_BITS'(1) << s_reg);
                    nonempty_next = 1'b1;
                    if (!nonempty_reg || (cur_id < lowest_reg))
                        lowest_next = cur_id;
                    if (!nonempty_reg || (cur_id > highest_reg))
                        highest_next = cur_id;
                end
                state_next = ST_OUT;
            end
            ST_TST:
            begin
                hit_next   = rdata[s_reg];
                state_next = ST_OUT;
            end
            ST_SRCH:
            begin
                if (scan.found)
                begin
                    hit_next   = 1'b1;
                    hole_next  = {w_reg, scan.pos};
                    state_next = ST_OUT;
                end
                else if (w_reg == top_word)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    w_next = w_reg + ibh_pkg::WADDR_W'(1);
                    s_next = '0;
                end
            end
            ST_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            w_reg        <= '0;
            s_reg        <= '0;
            hit_reg      <= 1'b0;
            hole_reg     <= '0;
            nonempty_reg <= 1'b0;
            lowest_reg   <= '0;
            highest_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            w_reg        <= w_next;
            s_reg        <= s_next;
            hit_reg      <= hit_next;
            hole_reg     <= hole_next;
            nonempty_reg <= nonempty_next;
            lowest_reg   <= lowest_next;
            highest_reg  <= highest_next;
        end
    end

    // one word in flight
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request taken while a result is pending");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("ready stayed high after accept");

    a_extremes_order: assert property (@(posedge clk) disable iff (!rst_n)
        nonempty_reg |-> (lowest_reg <= highest_reg))
        else $error("lowest above highest");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty_reg |-> (lowest_reg == '0 && highest_reg == '0))
        else $error("extremes nonzero on empty map");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH) |-> (nonempty_reg && (w_reg <= top_word)))
        else $error("scan past top word");

endmodule

/* tb/sv/tb_id_bitmap_with_hole_search_core.sv */
// Self-checking testbench for the identifier bitmap with hole search.
`timescale 1ns / 100ps

module tb_id_bitmap_with_hole_search_core;

    localparam int LIMIT_CYCLES = 8_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 2100;
    localparam int PHASE_WORDS  = 340;
    localparam int NUM_ROWS     = 22;

    typedef logic [ibh_pkg::ID_BITS-1:0] ident_t;

    typedef struct packed {
        logic   hit;
        ident_t hole_id;
        logic   any_present;
        ident_t lowest_id;
        ident_t highest_id;
    } bitmap_rsp_t;

    typedef struct packed {
        ibh_pkg::op_t op;
        ident_t       ident;
        logic         typed;
        logic         hit;
        ident_t       hole_id;
        logic         any_present;
        ident_t       lowest_id;
        ident_t       highest_id;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ibh_req_if req_ch();
    ibh_rsp_if rsp_ch();

    id_bitmap_with_hole_search_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow bitmap state
    logic [ibh_pkg::WORD_BITS-1:0] occ_map [ibh_pkg::NUM_WORDS] = '{default: '0};
    ident_t                        low_seen     = '0;
    ident_t                        high_seen    = '0;
    logic                          map_nonempty = 1'b0;

    bitmap_rsp_t rsp_expected_q [$];
    int          error_count = 0;
    int          cycle_count = 0;

    int unsigned req_idle_pct = 18;
    int unsigned rsp_idle_pct = 83;
    int          hold_asks    = 0;
    int          hold_done    = 0;
    int          hold_left    = 0;

    logic        cur_typed;
    bitmap_rsp_t cur_typed_rsp;

    stim_row_t directed_rows [NUM_ROWS];

    function automatic logic find_clear_id(input ident_t start, output ident_t spot);
        int   top_w;
        int   w;
        int   s;
        logic [ibh_pkg::WORD_BITS-1:0] wd;
        spot = '0;
        if (!map_nonempty)
            return 1'b0;
        top_w = int'(high_seen) / ibh_pkg::WORD_BITS;
        w     = int'(start) / ibh_pkg::WORD_BITS;
        s     = int'(start) % ibh_pkg::WORD_BITS;
        if (w > top_w)
            return 1'b0;
        while (w <= top_w && w < ibh_pkg::NUM_WORDS)
        begin
            wd = occ_map[w];
            while (s < ibh_pkg::WORD_BITS)
            begin
                if (!wd[s])
                begin
                    spot = ident_t'(w * ibh_pkg::WORD_BITS + s);
                    return 1'b1;
                end
                s++;
            end
            s = 0;
            w++;
        end
        return 1'b0;
    endfunction

    function automatic bitmap_rsp_t apply_bitmap_op(input ibh_pkg::op_t op, input ident_t id);
        bitmap_rsp_t r;
        ident_t      spot;
        int          w;
        int          s;
        r = '0;
        w = int'(id) / ibh_pkg::WORD_BITS;
        s = int'(id) % ibh_pkg::WORD_BITS;
        case (op)
            ibh_pkg::OP_INSERT:
            begin
                if (occ_map[w][s])
                    r.hit = 1'b1;
                else
                begin
                    occ_map[w][s] = 1'b1;
                    if (!map_nonempty)
                    begin
                        low_seen     = id;
                        high_seen    = id;
                        map_nonempty = 1'b1;
                    end
                    else
                    begin
                        if (id < low_seen)
                            low_seen = id;
                        if (id > high_seen)
                            high_seen = id;
                    end
                end
            end
            ibh_pkg::OP_TEST:
                r.hit = occ_map[w][s];
            ibh_pkg::OP_HOLE:
            begin
                if (find_clear_id(id, spot))
                begin
                    r.hit     = 1'b1;
                    r.hole_id = spot;
                end
            end
            default: ;
        endcase
        r.any_present = map_nonempty;
        r.lowest_id   = map_nonempty ? low_seen : '0;
        r.highest_id  = map_nonempty ? high_seen : '0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_id_bitmap_with_hole_search_core: done, errors");
            $finish;
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_asks != hold_done)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= hold_done + 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
    end

    // handshakes are stable between edges, so sample at the falling edge
    always @(negedge clk)
    begin
        bitmap_rsp_t exp_rsp;
        bitmap_rsp_t pred;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_expected_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    error_count++;
                end
                else
                begin
                    exp_rsp = rsp_expected_q.pop_front();
                    if (rsp_ch.hit !== exp_rsp.hit)
                    begin
                        $error("hit: expected %0h, got %0h", exp_rsp.hit, rsp_ch.hit);
                        error_count++;
                    end
                    if (rsp_ch.hole_id !== exp_rsp.hole_id)
                    begin
                        $error("hole_id: expected %0h, got %0h", exp_rsp.hole_id,
                               rsp_ch.hole_id);
                        error_count++;
                    end
                    if (rsp_ch.any_present !== exp_rsp.any_present)
                    begin
                        $error("any_present: expected %0h, got %0h", exp_rsp.any_present,
                               rsp_ch.any_present);
                        error_count++;
                    end
                    if (rsp_ch.lowest_id !== exp_rsp.lowest_id)
                    begin
                        $error("lowest_id: expected %0h, got %0h", exp_rsp.lowest_id,
                               rsp_ch.lowest_id);
                        error_count++;
                    end
                    if (rsp_ch.highest_id !== exp_rsp.highest_id)
                    begin
                        $error("highest_id: expected %0h, got %0h", exp_rsp.highest_id,
                               rsp_ch.highest_id);
                        error_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                pred = apply_bitmap_op(ibh_pkg::op_t'(req_ch.operation), req_ch.ident);
                rsp_expected_q.push_back(cur_typed ? cur_typed_rsp : pred);
            end
        end
    end

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input ibh_pkg::op_t op, input ident_t id, input logic typed,
                             input bitmap_rsp_t typed_rsp);
        logic took;
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.ident     <= id;
        cur_typed        <= typed;
        cur_typed_rsp    <= typed_rsp;
        do
        begin
            @(negedge clk);
            took = req_ch.ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic drain_expected();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (rsp_expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int unsigned words);
        int unsigned  done_words;
        int unsigned  roll;
        int unsigned  base_id;
        ibh_pkg::op_t op;
        ident_t       id;
        done_words = 0;
        base_id    = 0;
        while (done_words < words)
        begin
            if (done_words % 100 == 0)
                base_id = 32 * (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2046)
                                                            : $urandom_range(0, 15));
            if (done_words == words / 2)
                drain_expected();
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                id   = ident_t'(base_id + $urandom_range(0, 39));
                roll = $urandom_range(0, 99);
                op   = (roll < 50) ? ibh_pkg::OP_INSERT :
                       (roll < 75) ? ibh_pkg::OP_TEST : ibh_pkg::OP_HOLE;
            end
            else if (roll < 88)
            begin
                id = ident_t'($urandom);
                op = ibh_pkg::op_t'($urandom_range(1, 3));
            end
            else if (roll < 93)
            begin
                id = ident_t'($urandom);
                op = ibh_pkg::OP_INSERT;
            end
            else
            begin
                roll = $urandom_range(0, 2);
                id   = (roll == 0) ? '0 : (roll == 1) ? '1 : high_seen;
                op   = ibh_pkg::op_t'($urandom_range(0, 3));
            end
            send_word(op, id, 1'b0, '0);
            if (op != ibh_pkg::OP_NONE)
                done_words++;
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= ibh_pkg::OP_NONE;
        req_ch.ident     <= '0;
        cur_typed        <= 1'b0;
        cur_typed_rsp    <= '0;

        directed_rows = '{
            '{ibh_pkg::OP_TEST,   16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000},
            '{ibh_pkg::OP_HOLE,   16'h0005, 1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000},
            '{ibh_pkg::OP_NONE,   16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000},
            '{ibh_pkg::OP_INSERT, 16'h0040, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0040, 16'h0040},
            '{ibh_pkg::OP_INSERT, 16'h0040, 1'b1, 1'b1, 16'h0000, 1'b1, 16'h0040, 16'h0040},
            '{ibh_pkg::OP_HOLE,   16'h0060, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0040, 16'h0040},
            '{ibh_pkg::OP_HOLE,   16'h0041, 1'b1, 1'b1, 16'h0041, 1'b1, 16'h0040, 16'h0040},
            '{ibh_pkg::OP_HOLE,   16'h0040, 1'b1, 1'b1, 16'h0041, 1'b1, 16'h0040, 16'h0040},
            '{ibh_pkg::OP_HOLE,   16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 16'h0040, 16'h0040},
            '{ibh_pkg::OP_INSERT, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0000, 16'h0040},
            '{ibh_pkg::OP_INSERT, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
            '{ibh_pkg::OP_TEST,   16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
            '{ibh_pkg::OP_TEST,   16'hAAAA, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
            '{ibh_pkg::OP_TEST,   16'h5555, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
            '{ibh_pkg::OP_HOLE,   16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
            '{ibh_pkg::OP_HOLE,   16'hFFE0, 1'b1, 1'b1, 16'hFFE0, 1'b1, 16'h0000, 16'hFFFF},
            '{ibh_pkg::OP_INSERT, 16'h8000, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
            '{ibh_pkg::OP_NONE,   16'h1234, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
            '{ibh_pkg::OP_HOLE,   16'h7FFF, 1'b1, 1'b1, 16'h7FFF, 1'b1, 16'h0000, 16'hFFFF},
            '{ibh_pkg::OP_HOLE,   16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000},
            '{ibh_pkg::OP_INSERT, 16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000},
            '{ibh_pkg::OP_HOLE,   16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_word(directed_rows[i].op, directed_rows[i].ident, directed_rows[i].typed,
                      {directed_rows[i].hit, directed_rows[i].hole_id,
                       directed_rows[i].any_present, directed_rows[i].lowest_id,
                       directed_rows[i].highest_id});
        drain_expected();

        random_phase(PHASE_WORDS);
        drain_expected();

        req_idle_pct = 83;
        rsp_idle_pct = 18;
        hold_asks   <= hold_asks + 1;
        random_phase(PHASE_WORDS);
        drain_expected();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        random_phase(PHASE_WORDS);
        drain_expected();

        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && rsp_expected_q.size() == 0)
            $display("tb_id_bitmap_with_hole_search_core: done, clean");
        else
            $display("tb_id_bitmap_with_hole_search_core: done, errors");
        $finish;
    end

endmodule
